>>> rtl/synv_pkg.sv
package synv_pkg;

    localparam int NUM_VOICES_DEF  = 8;
    localparam int LEVEL_FLOOR_DEF = 1678;

    localparam int LEVEL_W  = 25;
    localparam int FACTOR_W = 24;
    localparam int KEY_W    = 7;
    localparam int AGE_W    = 32;
    localparam int VI_W     = 3;
    localparam int RCNT_W   = 4;
    localparam int PROD_W   = LEVEL_W + FACTOR_W;

    localparam logic [LEVEL_W-1:0] ONE_Q24 = LEVEL_W'(1 << 24);

    localparam logic [LEVEL_W-1:0]  ATTACK_STEP_RST    = LEVEL_W'(34);
    localparam logic [FACTOR_W-1:0] DECAY_FACTOR_RST   = FACTOR_W'(16772560);
    localparam logic [LEVEL_W-1:0]  SUS_LEVEL_RST      = LEVEL_W'(11744051);
    localparam logic [FACTOR_W-1:0] RELEASE_FACTOR_RST = FACTOR_W'(16770000);

    localparam logic [1:0] CFG_ATTACK_STEP    = 2'd0;
    localparam logic [1:0] CFG_DECAY_FACTOR   = 2'd1;
    localparam logic [1:0] CFG_SUS_LEVEL      = 2'd2;
    localparam logic [1:0] CFG_RELEASE_FACTOR = 2'd3;

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_ALL_OFF  = 2'd2,
        OP_TICK     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OFF     = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } stage_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_SCAN,
        S_PICK,
        S_ONWR,
        S_TWB,
        S_EMIT
    } fsm_t;

    typedef struct packed {
        logic               active;
        logic [KEY_W-1:0]   key;
        logic [AGE_W-1:0]   age;
        logic [2:0]         stage;
        logic [LEVEL_W-1:0] level;
    } voice_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]  attack_step;
        logic [FACTOR_W-1:0] decay_factor;
        logic [LEVEL_W-1:0]  sus_level;
        logic [FACTOR_W-1:0] release_factor;
    } env_cfg_t;

    typedef struct packed {
        logic [2:0]         stage;
        logic [LEVEL_W-1:0] level;
    } env_res_t;

endpackage

>>> rtl/synv_mem.sv
module synv_mem
    import synv_pkg::*;
#(
    parameter int NUM_VOICES = NUM_VOICES_DEF,
    parameter int IDX_W      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output voice_t           rd_data,
    input  logic             we,
    input  logic [IDX_W-1:0] wr_addr,
    input  voice_t           wr_data
);

    voice_t mem [NUM_VOICES];
    voice_t raw_reg;
    logic   rd_valid_reg;
    logic [NUM_VOICES-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            raw_reg <= mem[rd_addr];
        end
    end

    // entries never written read as the reset value (all zero, stage off)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? raw_reg : '0;

endmodule

>>> rtl/synv_env.sv
module synv_env
    import synv_pkg::*;
#(
    parameter int LEVEL_FLOOR = LEVEL_FLOOR_DEF
)
(
    input  logic               clk,
    input  logic               mul_en,
    input  logic [2:0]         stage,
    input  logic [LEVEL_W-1:0] level,
    input  env_cfg_t           cfg,
    output env_res_t           res
);

    localparam logic [LEVEL_W-1:0] FLOOR = LEVEL_W'(LEVEL_FLOOR);

    logic [PROD_W-1:0]   prod_reg;
    logic [LEVEL_W-1:0]  mul_a;
    logic [FACTOR_W-1:0] mul_b;
    logic [LEVEL_W-1:0]  scaled;
    logic [LEVEL_W:0]    att_sum;
    logic [LEVEL_W:0]    dec_sum;

    always_comb
    begin
        if (stage == ST_DECAY)
        begin
            mul_a = level - cfg.sus_level;
            mul_b = cfg.decay_factor;
        end
        else
        begin
            mul_a = level;
            mul_b = cfg.release_factor;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
    end

    assign scaled  = prod_reg[PROD_W-1:24];
    assign att_sum = {1'b0, level} + {1'b0, cfg.attack_step};
    assign dec_sum = {1'b0, cfg.sus_level} + {1'b0, scaled};

    always_comb
    begin
        res.stage = ST_OFF;
        res.level = '0;
        unique case (stage)
            ST_ATTACK:
            begin
                if (att_sum >= {1'b0, ONE_Q24})
                begin
                    res.stage = ST_DECAY;
                    res.level = ONE_Q24;
                end
                else
                begin
                    res.stage = ST_ATTACK;
                    res.level = att_sum[LEVEL_W-1:0];
                end
            end
            ST_DECAY:
            begin
                if (level <= cfg.sus_level || scaled <= FLOOR)
                begin
                    res.stage = ST_SUSTAIN;
                    res.level = cfg.sus_level;
                end
                else
                begin
                    res.stage = ST_DECAY;
                    res.level = dec_sum[LEVEL_W-1:0];
                end
            end
            ST_SUSTAIN:
            begin
                res.stage = ST_SUSTAIN;
                res.level = cfg.sus_level;
            end
            ST_RELEASE:
            begin
                if (scaled < FLOOR)
                begin
                    res.stage = ST_OFF;
                    res.level = '0;
                end
                else
                begin
                    res.stage = ST_RELEASE;
                    res.level = scaled;
                end
            end
            default:
            begin
                res.stage = ST_OFF;
                res.level = '0;
            end
        endcase
    end

endmodule

>>> rtl/synth_voice_allocator_adsr_unit.sv
// Polyphonic voice allocator with one ADSR amplitude envelope per voice.
// Input channel s_*: tuser carries the op (note on, note off, all off, tick),
// tdata the note number. Output channel m_*: one item per note on, note off
// and all off; NUM_VOICES items per tick in voice order, tlast on the final.
// Configuration: cfg_we/cfg_index/cfg_data write one envelope register per
// clock; write only while idle.
// Voice state sits in a one-port-read, one-port-write synchronous memory; the
// sequencer walks it one voice at a time (read, then modify and write back).
// A tick reads each voice, registers its envelope product and writes it back;
// a note on scans all voices, rereads the chosen one and writes it; note off
// and all off update voices during the scan, then emit one item.
// s_tready is high only between items. A stalled receiver holds the single
// output register; the walk waits on it and resumes when it drains.
// Reset (rst_n, async low) clears the voice table through per-entry valid
// bits, loads the register defaults and takes effect at once, no sweep.
module synth_voice_allocator_adsr_unit
    import synv_pkg::*;
#(
    parameter int NUM_VOICES  = NUM_VOICES_DEF,
    parameter int LEVEL_FLOOR = LEVEL_FLOOR_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [6:0] note_number
    input  logic [1:0]   s_tuser,   // [1:0] op
    output logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] voice_index, [9:3] voice_note, [12:10] env_stage_out,
    // [37:13] env_level_out, [41:38] released_count
    output logic [47:0]  m_tdata,
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [24:0]  cfg_data
);

    localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CNT_W = $clog2(NUM_VOICES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VOICES - 1);

    env_cfg_t cfg_reg;

    fsm_t             state_reg, state_next;
    op_t              op_reg;
    logic [KEY_W-1:0] note_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [AGE_W-1:0] age_cnt_reg, age_cnt_next;

    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             rel_found_reg, rel_found_next;
    logic [IDX_W-1:0] rel_idx_reg, rel_idx_next;
    logic [AGE_W-1:0] rel_age_reg, rel_age_next;
    logic [IDX_W-1:0] old_idx_reg, old_idx_next;
    logic [AGE_W-1:0] old_age_reg, old_age_next;

    logic               out_valid_reg;
    logic [VI_W-1:0]    out_vi_reg, out_vi_next;
    logic [KEY_W-1:0]   out_note_reg, out_note_next;
    logic [2:0]         out_stage_reg, out_stage_next;
    logic [LEVEL_W-1:0] out_level_reg, out_level_next;
    logic [RCNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic               out_last_reg, out_last_next;
    logic               out_load;

    logic             slot_free;
    logic             accept;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    voice_t           rd_data;
    logic             mem_we;
    voice_t           wr_data;
    logic             mul_en;
    env_res_t         env_res;
    logic [IDX_W-1:0] pick_idx;
    logic [RCNT_W-1:0] cnt_sat;

    synv_mem #(
        .NUM_VOICES (NUM_VOICES),
        .IDX_W      (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .we      (mem_we),
        .wr_addr (idx_reg),
        .wr_data (wr_data)
    );

    synv_env #(
        .LEVEL_FLOOR (LEVEL_FLOOR)
    ) u_env (
        .clk    (clk),
        .mul_en (mul_en),
        .stage  (rd_data.stage),
        .level  (rd_data.level),
        .cfg    (cfg_reg),
        .res    (env_res)
    );

    assign slot_free = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign pick_idx  = free_found_reg ? free_idx_reg :
                       (rel_found_reg ? rel_idx_reg : old_idx_reg);
    assign cnt_sat   = (32'(cnt_reg) > 32'd15) ? RCNT_W'(15) : RCNT_W'(cnt_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (op_reg == OP_TICK)
                begin
                    state_next = S_TWB;
                end
                else if (idx_reg != LAST_IDX)
                begin
                    state_next = S_RD;
                end
                else if (op_reg == OP_NOTE_ON)
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_PICK:
            begin
                state_next = S_ONWR;
            end
            S_ONWR, S_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_TWB:
            begin
                if (slot_free)
                begin
                    state_next = (idx_reg == LAST_IDX) ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        s_tready        = (state_reg == S_IDLE);
        rd_en           = 1'b0;
        rd_addr         = idx_reg;
        mem_we          = 1'b0;
        wr_data         = rd_data;
        mul_en          = 1'b0;
        out_load        = 1'b0;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        age_cnt_next    = age_cnt_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        rel_found_next  = rel_found_reg;
        rel_idx_next    = rel_idx_reg;
        rel_age_next    = rel_age_reg;
        old_idx_next    = old_idx_reg;
        old_age_next    = old_age_reg;
        out_vi_next     = '0;
        out_note_next   = '0;
        out_stage_next  = ST_OFF;
        out_level_next  = '0;
        out_cnt_next    = '0;
        out_last_next   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                idx_next        = '0;
                cnt_next        = '0;
                free_found_next = 1'b0;
                rel_found_next  = 1'b0;
            end
            S_RD:
            begin
                rd_en = 1'b1;
            end
            S_SCAN:
            begin
                mul_en = (op_reg == OP_TICK);
                if (op_reg != OP_TICK && idx_reg != LAST_IDX)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                unique case (op_reg)
                    OP_NOTE_ON:
                    begin
                        if (!free_found_reg && !rd_data.active && rd_data.stage == ST_OFF)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = idx_reg;
                        end
                        if (rd_data.stage == ST_RELEASE &&
                            (!rel_found_reg || rd_data.age < rel_age_reg))
                        begin
                            rel_found_next = 1'b1;
                            rel_idx_next   = idx_reg;
                            rel_age_next   = rd_data.age;
                        end
                        if (idx_reg == '0 || rd_data.age < old_age_reg)
                        begin
                            old_idx_next = idx_reg;
                            old_age_next = rd_data.age;
                        end
                    end
                    OP_NOTE_OFF:
                    begin
                        if (rd_data.active && rd_data.key == note_reg &&
                            rd_data.stage != ST_RELEASE)
                        begin
                            mem_we         = 1'b1;
                            wr_data.active = 1'b0;
                            wr_data.stage  = ST_RELEASE;
                            cnt_next       = cnt_reg + 1'b1;
                        end
                    end
                    OP_ALL_OFF:
                    begin
                        mem_we         = 1'b1;
                        wr_data.active = 1'b0;
                        wr_data.stage  = ST_OFF;
                        wr_data.level  = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_PICK:
            begin
                rd_en    = 1'b1;
                rd_addr  = pick_idx;
                idx_next = pick_idx;
            end
            S_ONWR:
            begin
                if (slot_free)
                begin
                    mem_we         = 1'b1;
                    wr_data.active = 1'b1;
                    wr_data.key    = note_reg;
                    wr_data.age    = age_cnt_reg;
                    wr_data.stage  = ST_ATTACK;
                    age_cnt_next   = age_cnt_reg + 1'b1;
                    out_load       = 1'b1;
                    out_vi_next    = VI_W'(idx_reg);
                    out_note_next  = note_reg;
                    out_stage_next = ST_ATTACK;
                    out_level_next = rd_data.level;
                end
            end
            S_TWB:
            begin
                if (slot_free)
                begin
                    mem_we         = 1'b1;
                    wr_data.stage  = env_res.stage;
                    wr_data.level  = env_res.level;
                    out_load       = 1'b1;
                    out_vi_next    = VI_W'(idx_reg);
                    out_note_next  = rd_data.key;
                    out_stage_next = env_res.stage;
                    out_level_next = env_res.level;
                    out_last_next  = (idx_reg == LAST_IDX);
                    if (idx_reg != LAST_IDX)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_load     = 1'b1;
                    out_cnt_next = cnt_sat;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg              <= S_IDLE;
            age_cnt_reg            <= '0;
            out_valid_reg          <= 1'b0;
            cfg_reg.attack_step    <= ATTACK_STEP_RST;
            cfg_reg.decay_factor   <= DECAY_FACTOR_RST;
            cfg_reg.sus_level      <= SUS_LEVEL_RST;
            cfg_reg.release_factor <= RELEASE_FACTOR_RST;
        end
        else
        begin
            state_reg   <= state_next;
            age_cnt_reg <= age_cnt_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ATTACK_STEP:    cfg_reg.attack_step    <= cfg_data;
                    CFG_DECAY_FACTOR:   cfg_reg.decay_factor   <= cfg_data[FACTOR_W-1:0];
                    CFG_SUS_LEVEL:      cfg_reg.sus_level      <= cfg_data;
                    CFG_RELEASE_FACTOR: cfg_reg.release_factor <= cfg_data[FACTOR_W-1:0];
                    default:            cfg_reg                <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(s_tuser);
            note_reg <= s_tdata[KEY_W-1:0];
        end
        idx_reg        <= idx_next;
        cnt_reg        <= cnt_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        rel_found_reg  <= rel_found_next;
        rel_idx_reg    <= rel_idx_next;
        rel_age_reg    <= rel_age_next;
        old_idx_reg    <= old_idx_next;
        old_age_reg    <= old_age_next;
        if (out_load)
        begin
            out_vi_reg    <= out_vi_next;
            out_note_reg  <= out_note_next;
            out_stage_reg <= out_stage_next;
            out_level_reg <= out_level_next;
            out_cnt_reg   <= out_cnt_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'd0, out_cnt_reg, out_level_reg, out_stage_reg,
                       out_note_reg, out_vi_reg};

    a_we_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg != S_IDLE)
        else $error("voice table written while idle");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("result overwritten while stalled");

    a_age_step: assert property (@(posedge clk) disable iff (!rst_n)
        age_cnt_reg != $past(age_cnt_reg) |-> $past(state_reg) == S_ONWR)
        else $error("age counter moved outside note on");

    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ONWR && slot_free) |=> state_reg == S_IDLE && out_valid_reg)
        else $error("note on result missing");

endmodule
